// ===== rtl/opet_pkg.sv =====
// Package for the one-shot/periodic event timer: field widths, command,
// mode and register index codes, and the structs passed between modules.
// No dependencies.
package opet_pkg;

    localparam int CMD_W   = 2;
    localparam int TIME_W  = 63;
    localparam int FREQ_W  = 32;
    localparam int VEC_W   = 8;
    localparam int CNT_W   = 64;
    localparam int MODE_W  = 2;
    localparam int TICKS_W = 32;
    localparam int WIDX_W  = 2;
    localparam int WDATA_W = 32;

    // Commands carried by an input item
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Timer modes
    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd2;

    // Configuration register indexes
    localparam logic [WIDX_W-1:0] REG_TICK_FREQUENCY = 2'd0;
    localparam logic [WIDX_W-1:0] REG_VECTOR_NUMBER  = 2'd1;
    localparam logic [WIDX_W-1:0] REG_EVENTS_ENABLED = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd100000000;

    // Per-item control traveling alongside the tick conversion pipeline
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             first_nz;
        logic             period_nz;
    } opet_side_t;

    // One result item
    typedef struct packed {
        logic              fired;
        logic              event_delivered;
        logic [VEC_W-1:0]  fired_vector;
        logic [CNT_W-1:0]  latched_count;
        logic [MODE_W-1:0] timer_mode;
        logic              is_masked;
    } opet_result_t;

endpackage

// ===== rtl/opet_if.sv =====
// Valid/ready channel interfaces for timer commands and timer results.
// Depends on opet_pkg.
interface opet_in_if import opet_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] first_delay;
    logic [TIME_W-1:0] period_time;

    modport source (output valid, command, first_delay, period_time, input ready);
    modport sink   (input valid, command, first_delay, period_time, output ready);
endinterface

interface opet_out_if import opet_pkg::*;;
    logic              valid;
    logic              ready;
    logic              fired;
    logic              event_delivered;
    logic [VEC_W-1:0]  fired_vector;
    logic [CNT_W-1:0]  latched_count;
    logic [MODE_W-1:0] timer_mode;
    logic              is_masked;

    modport source (output valid, fired, event_delivered, fired_vector, latched_count,
                    timer_mode, is_masked, input ready);
    modport sink   (input valid, fired, event_delivered, fired_vector, latched_count,
                    timer_mode, is_masked, output ready);
endinterface

// ===== rtl/opet_conv.sv =====
// Two-stage conversion of 31.32 seconds to ticks: ((freq * t) mod 2^64) >> 32.
// Depends on opet_pkg.
module opet_conv import opet_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [FREQ_W-1:0]  freq,
    input  logic [TIME_W-1:0]  t,
    output logic [TICKS_W-1:0] ticks
);

    logic [63:0]        prod_lo;
    logic [63:0]        prod_hi;
    logic [TICKS_W-1:0] lo_part_reg;
    logic [TICKS_W-1:0] hi_part_reg;
    logic [TICKS_W-1:0] ticks_reg;

    // Only bits 63:32 of the wrapped product survive: the upper half of
    // freq * t[31:0] plus the lower half of freq * t[62:32].
    assign prod_lo = 64'(freq) * 64'(t[31:0]);
    assign prod_hi = 64'(freq) * 64'(t[TIME_W-1:32]);

    // Stage 1: partial products, stage 2: combine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_part_reg <= prod_lo[63:32];
            hi_part_reg <= prod_hi[31:0];
            ticks_reg   <= lo_part_reg + hi_part_reg;
        end
    end

    assign ticks = ticks_reg;

endmodule

// ===== rtl/opet_core.sv =====
// Timer state update stage: counter, match, mask, mode and capture, plus the
// result register. Depends on opet_pkg.
module opet_core import opet_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               item_valid,
    input  opet_side_t         side,
    input  logic [TICKS_W-1:0] first_ticks,
    input  logic [TICKS_W-1:0] period_ticks,
    input  logic [VEC_W-1:0]   vector_number,
    input  logic               events_enabled,
    output logic               res_valid,
    output opet_result_t       res
);

    logic [CNT_W-1:0]  tick_count_reg, tick_count_next;
    logic [CNT_W-1:0]  match_reg, match_next;
    logic [CNT_W-1:0]  reload_reg, reload_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              mask_reg, mask_next;
    logic [CNT_W-1:0]  capture_reg, capture_next;
    logic              res_valid_reg;
    opet_result_t      res_reg, res_next;
    logic              upd;
    logic              fire;
    logic [CNT_W-1:0]  delay;

    assign upd  = en && item_valid;
    assign fire = (side.command == CMD_TICK) && !mask_reg && (tick_count_reg == match_reg);

    // Next state for one item
    always_comb
    begin
        tick_count_next = tick_count_reg;
        match_next      = match_reg;
        reload_next     = reload_reg;
        mode_next       = mode_reg;
        mask_next       = mask_reg;
        capture_next    = capture_reg;
        delay           = '0;
        case (side.command)
            CMD_TICK:
            begin
                if (fire)
                begin
                    capture_next = tick_count_reg;
                    if (mode_reg == MODE_PERIODIC)
                        match_next = tick_count_reg + reload_reg;
                    else
                        mask_next = 1'b1;
                end
                tick_count_next = tick_count_reg + 64'd1;
            end
            CMD_START:
            begin
                if (side.period_nz)
                begin
                    mode_next   = MODE_PERIODIC;
                    reload_next = CNT_W'(period_ticks);
                end
                else
                begin
                    mode_next   = MODE_ONESHOT;
                    reload_next = '0;
                end
                delay      = side.first_nz ? CNT_W'(first_ticks) : reload_next;
                match_next = tick_count_reg + delay;
                mask_next  = 1'b0;
            end
            CMD_STOP:
            begin
                mask_next   = 1'b1;
                mode_next   = MODE_OFF;
                reload_next = '0;
            end
            default:
            begin
            end
        endcase

        res_next.fired           = fire;
        res_next.event_delivered = fire && events_enabled;
        res_next.fired_vector    = fire ? vector_number : '0;
        res_next.latched_count   = capture_next;
        res_next.timer_mode      = mode_next;
        res_next.is_masked       = mask_next;
    end

    // Timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            match_reg      <= '0;
            reload_reg     <= '0;
            mode_reg       <= MODE_OFF;
            mask_reg       <= 1'b1;
            capture_reg    <= '0;
        end
        else if (upd)
        begin
            tick_count_reg <= tick_count_next;
            match_reg      <= match_next;
            reload_reg     <= reload_next;
            mode_reg       <= mode_next;
            mask_reg       <= mask_next;
            capture_reg    <= capture_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= item_valid;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (upd)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A timer that is off never has its match armed
    a_off_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OFF) |-> mask_reg)
        else $error("timer off but unmasked");

    // Only a periodic timer keeps a reload value
    a_reload_periodic: assert property (@(posedge clk) disable iff (!rst_n)
        (reload_reg != '0) |-> (mode_reg == MODE_PERIODIC))
        else $error("reload value outside periodic mode");

    // A tick advances the counter by exactly one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && side.command == CMD_TICK) |=> (tick_count_reg == $past(tick_count_reg) + 64'd1))
        else $error("counter did not advance on tick");

    // A fire captures the count it matched on
    a_fire_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && fire) |=> (capture_reg == $past(tick_count_reg) && res_reg.fired))
        else $error("fire not captured");

endmodule

// ===== rtl/oneshot_periodic_event_timer_unit.sv =====
// Top level of the one-shot/periodic event timer: input stage, configuration
// registers, tick conversion pipeline and state update. Depends on opet_pkg,
// opet_if, opet_conv and opet_core.

// The timer takes one item per clock cycle (tick, start or stop) while it is not
// stalled, and returns one result item for each, in order. Each item passes the
// input register, the two stages that turn 31.32 seconds into ticks (a 32x32 and
// a 32x31 multiplier, then an add) and the state update stage that writes the
// result register; the result is then valid and is taken when the result side
// is ready. The whole pipeline advances together and stalls only while a result
// waits to be taken. Configuration writes are taken at any edge but must only be
// made while the timer holds no items in flight.
module oneshot_periodic_event_timer_unit import opet_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    opet_in_if.sink            in_ch,
    opet_out_if.source         out_ch,
    input  logic               wr_en,
    input  logic [WIDX_W-1:0]  wr_index,
    input  logic [WDATA_W-1:0] wr_data
);

    logic [FREQ_W-1:0]  freq_reg;
    logic [VEC_W-1:0]   vector_reg;
    logic               events_reg;
    logic               en;
    logic               v0_reg, v1_reg, v2_reg;
    logic [CMD_W-1:0]   cmd0_reg;
    logic [TIME_W-1:0]  first0_reg;
    logic [TIME_W-1:0]  period0_reg;
    opet_side_t         side1_reg, side2_reg;
    logic [TICKS_W-1:0] first_ticks;
    logic [TICKS_W-1:0] period_ticks;
    logic               res_valid;
    opet_result_t       res;

    // Pipeline moves whenever the result register is empty or being taken
    assign en          = !res_valid || out_ch.ready;
    assign in_ch.ready = en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= FREQ_RESET;
            vector_reg <= '0;
            events_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TICK_FREQUENCY: freq_reg   <= wr_data[FREQ_W-1:0];
                REG_VECTOR_NUMBER:  vector_reg <= wr_data[VEC_W-1:0];
                REG_EVENTS_ENABLED: events_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_ch.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Input register and side-band alongside the conversion
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd0_reg            <= in_ch.command;
            first0_reg          <= in_ch.first_delay;
            period0_reg         <= in_ch.period_time;
            side1_reg.command   <= cmd0_reg;
            side1_reg.first_nz  <= |first0_reg;
            side1_reg.period_nz <= |period0_reg;
            side2_reg           <= side1_reg;
        end
    end

    opet_conv u_conv_first (
        .clk   (clk),
        .en    (en),
        .freq  (freq_reg),
        .t     (first0_reg),
        .ticks (first_ticks)
    );

    opet_conv u_conv_period (
        .clk   (clk),
        .en    (en),
        .freq  (freq_reg),
        .t     (period0_reg),
        .ticks (period_ticks)
    );

    opet_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .item_valid     (v2_reg),
        .side           (side2_reg),
        .first_ticks    (first_ticks),
        .period_ticks   (period_ticks),
        .vector_number  (vector_reg),
        .events_enabled (events_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Result channel
    assign out_ch.valid           = res_valid;
    assign out_ch.fired           = res.fired;
    assign out_ch.event_delivered = res.event_delivered;
    assign out_ch.fired_vector    = res.fired_vector;
    assign out_ch.latched_count   = res.latched_count;
    assign out_ch.timer_mode      = res.timer_mode;
    assign out_ch.is_masked       = res.is_masked;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for oneshot_periodic_event_timer_unit: directed items, then
// random tick/start/stop traffic checked against a cycle-free prediction of the timer.
// Depends on opet_pkg, opet_if and the timer RTL.
`timescale 1ns / 100ps

module testbench;
    import opet_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED      = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};
    localparam int                DRAIN_CYCLES    = 8;
    localparam int                QUIET_LIMIT     = 5000;
    localparam int                PHASE_ITEMS     = 250;
    localparam int                HOLD_OFF_CYCLES = 400;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CMD_W-1:0]   command;
        logic [TIME_W-1:0]  first_delay;
        logic [TIME_W-1:0]  period_time;
        opet_result_t       outcome;
        logic [WIDX_W-1:0]  reg_index;
        logic [WDATA_W-1:0] reg_data;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               wr_en;
    logic [WIDX_W-1:0]  wr_index;
    logic [WDATA_W-1:0] wr_data;

    opet_in_if  cmd_ch();
    opet_out_if res_ch();

    oneshot_periodic_event_timer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (cmd_ch),
        .out_ch   (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predicted timer state and register copies
    logic [CNT_W-1:0]  timer_count;
    logic [CNT_W-1:0]  timer_match;
    logic [CNT_W-1:0]  timer_reload;
    logic [CNT_W-1:0]  timer_capture;
    logic [MODE_W-1:0] timer_mode;
    logic              timer_masked;
    logic [FREQ_W-1:0] cfg_freq;
    logic [VEC_W-1:0]  cfg_vector;
    logic              cfg_events;

    opet_result_t due_results[$];
    stim_row_t    directed[$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int quiet_cycles    = 0;
    int hold_off_left;
    int hold_off_requests;
    int hold_off_served;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 31.32 seconds to ticks; the 64-bit product wraps
    function automatic logic [CNT_W-1:0] seconds_to_ticks(logic [TIME_W-1:0] t);
        logic [CNT_W-1:0] product;
        product = CNT_W'(cfg_freq) * CNT_W'(t);
        return product >> 32;
    endfunction

    // Smallest time that converts to exactly k ticks at the current frequency
    function automatic logic [TIME_W-1:0] time_for_ticks(int unsigned k);
        logic [CNT_W-1:0] scaled;
        scaled = (CNT_W'(k) << 32) + CNT_W'(cfg_freq) - 1;
        return TIME_W'(scaled / CNT_W'(cfg_freq));
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Apply one item to the predicted state and return the result it yields
    function automatic opet_result_t advance_timer(logic [CMD_W-1:0] cmd,
                                                   logic [TIME_W-1:0] first,
                                                   logic [TIME_W-1:0] period);
        opet_result_t     r;
        logic [CNT_W-1:0] delay;
        logic             hit;
        hit = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                if (!timer_masked && timer_count == timer_match)
                begin
                    hit = 1'b1;
                    timer_capture = timer_count;
                    if (timer_mode == MODE_PERIODIC)
                        timer_match = timer_count + timer_reload;
                    else
                        timer_masked = 1'b1;
                end
                timer_count = timer_count + 64'd1;
            end
            CMD_START:
            begin
                if (period != '0)
                begin
                    timer_mode   = MODE_PERIODIC;
                    timer_reload = seconds_to_ticks(period);
                end
                else
                begin
                    timer_mode   = MODE_ONESHOT;
                    timer_reload = '0;
                end
                delay = (first != '0) ? seconds_to_ticks(first) : timer_reload;
                timer_match  = timer_count + delay;
                timer_masked = 1'b0;
            end
            CMD_STOP:
            begin
                timer_masked = 1'b1;
                timer_mode   = MODE_OFF;
                timer_reload = '0;
            end
            default: ;
        endcase
        r.fired           = hit;
        r.event_delivered = hit & cfg_events;
        r.fired_vector    = hit ? cfg_vector : '0;
        r.latched_count   = timer_capture;
        r.timer_mode      = timer_mode;
        r.is_masked       = timer_masked;
        return r;
    endfunction

    // Directed table rows
    function automatic stim_row_t predicted_row(logic [CMD_W-1:0] cmd,
                                                logic [TIME_W-1:0] first,
                                                logic [TIME_W-1:0] period);
        stim_row_t row;
        row.kind        = ROW_PREDICT;
        row.command     = cmd;
        row.first_delay = first;
        row.period_time = period;
        row.outcome     = '0;
        row.reg_index   = '0;
        row.reg_data    = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] first,
                                            logic [TIME_W-1:0] period, logic fired,
                                            logic delivered, logic [VEC_W-1:0] vec,
                                            logic [CNT_W-1:0] latched,
                                            logic [MODE_W-1:0] mode, logic masked);
        stim_row_t row;
        row = predicted_row(cmd, first, period);
        row.kind                    = ROW_TYPED;
        row.outcome.fired           = fired;
        row.outcome.event_delivered = delivered;
        row.outcome.fired_vector    = vec;
        row.outcome.latched_count   = latched;
        row.outcome.timer_mode      = mode;
        row.outcome.is_masked       = masked;
        return row;
    endfunction

    function automatic stim_row_t write_row(logic [WIDX_W-1:0] idx, logic [WDATA_W-1:0] data);
        stim_row_t row;
        row = predicted_row(CMD_TICK, '0, '0);
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_data  = data;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch: %s at result %0d: got %0h, expected %0h",
                 what, results_checked, got, want);
    endtask

    // Register write; called only while no items are in flight
    task automatic write_register(logic [WIDX_W-1:0] idx, logic [WDATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TICK_FREQUENCY: cfg_freq   = data[FREQ_W-1:0];
            REG_VECTOR_NUMBER:  cfg_vector = data[VEC_W-1:0];
            REG_EVENTS_ENABLED: cfg_events = data[0];
            default: ;
        endcase
    endtask

    // Offer one item, wait for it to be taken, then queue its expected result
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] first,
                             logic [TIME_W-1:0] period, logic typed,
                             opet_result_t typed_result);
        opet_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.first_delay <= first;
        cmd_ch.period_time <= period;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = advance_timer(cmd, first, period);
        due_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random traffic: mostly start followed by a run of ticks, plus noise
    task automatic run_phase(int items);
        int                sent;
        int unsigned       pick;
        int unsigned       n;
        logic [TIME_W-1:0] first_t;
        logic [TIME_W-1:0] period_t;
        logic [CMD_W-1:0]  cmd;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                n = $urandom_range(12);
                first_t  = (n == 0) ? TIME_W'($urandom_range(1)) : time_for_ticks(n);
                period_t = $urandom_range(1) ? '0 : time_for_ticks($urandom_range(8));
                // a nonzero period that converts to zero ticks
                if ($urandom_range(9) == 0)
                    period_t = TIME_W'(1);
                send_item(CMD_START, first_t, period_t, 1'b0, '0);
                sent++;
                n = $urandom_range(1, 30);
                repeat (n)
                begin
                    send_item(CMD_TICK, random_time(), random_time(), 1'b0, '0);
                    sent++;
                end
                if ($urandom_range(4) == 0)
                begin
                    send_item(CMD_STOP, random_time(), random_time(), 1'b0, '0);
                    sent++;
                end
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                begin
                    send_item(CMD_TICK, random_time(), random_time(), 1'b0, '0);
                    sent++;
                end
            end
            else if (pick < 95)
            begin
                cmd = CMD_W'($urandom_range(3));
                send_item(cmd, random_time(), random_time(), 1'b0, '0);
                if (cmd != CMD_UNUSED)
                    sent++;
            end
            else
            begin
                send_item(CMD_STOP, '0, '0, 1'b0, '0);
                send_item(CMD_TICK, '0, '0, 1'b0, '0);
                sent += 2;
            end
        end
    endtask

    // Result receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready    <= 1'b0;
            hold_off_left   <= 0;
            hold_off_served <= 0;
        end
        else if (hold_off_served != hold_off_requests)
        begin
            hold_off_served <= hold_off_requests;
            hold_off_left   <= HOLD_OFF_CYCLES;
            res_ch.ready    <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
            res_ch.ready  <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        opet_result_t got;
        opet_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.fired           = res_ch.fired;
            got.event_delivered = res_ch.event_delivered;
            got.fired_vector    = res_ch.fired_vector;
            got.latched_count   = res_ch.latched_count;
            got.timer_mode      = res_ch.timer_mode;
            got.is_masked       = res_ch.is_masked;
            if (due_results.size() == 0)
                report_mismatch("result with nothing expected", 64'(got), 64'd0);
            else
            begin
                want = due_results.pop_front();
                if (got.fired !== want.fired)
                    report_mismatch("fired", 64'(got.fired), 64'(want.fired));
                if (got.event_delivered !== want.event_delivered)
                    report_mismatch("event_delivered", 64'(got.event_delivered),
                                    64'(want.event_delivered));
                if (got.fired_vector !== want.fired_vector)
                    report_mismatch("fired_vector", 64'(got.fired_vector),
                                    64'(want.fired_vector));
                if (got.latched_count !== want.latched_count)
                    report_mismatch("latched_count", got.latched_count, want.latched_count);
                if (got.timer_mode !== want.timer_mode)
                    report_mismatch("timer_mode", 64'(got.timer_mode), 64'(want.timer_mode));
                if (got.is_masked !== want.is_masked)
                    report_mismatch("is_masked", 64'(got.is_masked), 64'(want.is_masked));
            end
            results_checked++;
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        logic [FREQ_W-1:0] freq_pick;
        logic [VEC_W-1:0]  vector_pick;

        rst_n              <= 1'b0;
        wr_en              <= 1'b0;
        wr_index           <= REG_TICK_FREQUENCY;
        wr_data            <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.command     <= CMD_TICK;
        cmd_ch.first_delay <= '0;
        cmd_ch.period_time <= '0;

        timer_count       = '0;
        timer_match       = '0;
        timer_reload      = '0;
        timer_capture     = '0;
        timer_mode        = MODE_OFF;
        timer_masked      = 1'b1;
        cfg_freq          = FREQ_RESET;
        cfg_vector        = '0;
        cfg_events        = 1'b0;
        hold_off_requests = 0;
        send_idle_pct     = 10;
        recv_idle_pct     = 83;

        // After reset; unused command; one-shot with zero delay fires at once
        directed.push_back(typed_row(CMD_TICK, '0, '0, 1'b0, 1'b0, 8'd0, 64'd0,
                                     MODE_OFF, 1'b1));
        directed.push_back(typed_row(CMD_UNUSED, TIME_MAX, TIME_MAX, 1'b0, 1'b0, 8'd0, 64'd0,
                                     MODE_OFF, 1'b1));
        directed.push_back(typed_row(CMD_STOP, '0, '0, 1'b0, 1'b0, 8'd0, 64'd0,
                                     MODE_OFF, 1'b1));
        directed.push_back(typed_row(CMD_START, '0, '0, 1'b0, 1'b0, 8'd0, 64'd0,
                                     MODE_ONESHOT, 1'b0));
        directed.push_back(typed_row(CMD_TICK, '0, '0, 1'b1, 1'b0, 8'd0, 64'd1,
                                     MODE_ONESHOT, 1'b1));
        directed.push_back(typed_row(CMD_TICK, TIME_MAX, TIME_MAX, 1'b0, 1'b0, 8'd0, 64'd1,
                                     MODE_ONESHOT, 1'b1));
        directed.push_back(write_row(REG_VECTOR_NUMBER, 32'd255));
        directed.push_back(write_row(REG_EVENTS_ENABLED, 32'd1));
        // One-shot after three ticks
        directed.push_back(predicted_row(CMD_START, 63'd129, '0));
        repeat (4) directed.push_back(predicted_row(CMD_TICK, '0, '0));
        // Periodic every two ticks, first delay taken from the period
        directed.push_back(predicted_row(CMD_START, '0, 63'd86));
        repeat (3) directed.push_back(predicted_row(CMD_TICK, '0, '0));
        // Nonzero period that converts to zero ticks: one fire, then quiet
        directed.push_back(predicted_row(CMD_START, '0, 63'd1));
        repeat (2) directed.push_back(predicted_row(CMD_TICK, '0, '0));
        directed.push_back(typed_row(CMD_STOP, '0, '0, 1'b0, 1'b0, 8'd0, 64'd10,
                                     MODE_OFF, 1'b1));
        // Largest times: the product wraps
        directed.push_back(predicted_row(CMD_START, TIME_MAX, TIME_MAX));
        directed.push_back(predicted_row(CMD_TICK, '0, '0));
        directed.push_back(predicted_row(CMD_STOP, TIME_MAX, TIME_MAX));
        // Highest frequency, nonzero first delay that converts to zero ticks
        directed.push_back(write_row(REG_TICK_FREQUENCY, 32'hFFFF_FFFF));
        directed.push_back(predicted_row(CMD_START, 63'd1, '0));
        repeat (2) directed.push_back(predicted_row(CMD_TICK, '0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_register(directed[i].reg_index, directed[i].reg_data);
            end
            else
                send_item(directed[i].command, directed[i].first_delay,
                          directed[i].period_time, directed[i].kind == ROW_TYPED,
                          directed[i].outcome);
        end
        drain_results();

        // Random phases, each with its own register setting and idling pattern
        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 83 : 0;
            recv_idle_pct = (phase < 2) ? 83 : (phase < 4) ? 10 : 0;
            case (phase)
                0: freq_pick = FREQ_RESET;
                1: freq_pick = 32'd1;
                2: freq_pick = 32'hFFFF_FFFF;
                3: freq_pick = 32'd1 << 16;
                default: freq_pick = $urandom_range(32'hFFFF_FFFF, 1);
            endcase
            case (phase)
                0: vector_pick = '0;
                1: vector_pick = 8'hFF;
                default: vector_pick = VEC_W'($urandom_range(255));
            endcase
            write_register(REG_TICK_FREQUENCY, freq_pick);
            write_register(REG_VECTOR_NUMBER, WDATA_W'(vector_pick));
            write_register(REG_EVENTS_ENABLED, WDATA_W'(phase % 2));
            // receiver holds off long enough for the pipeline to back up
            if (phase == 5)
                hold_off_requests++;
            run_phase(PHASE_ITEMS);
            drain_results();
        end

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
